/* rtl/flbc_pkg.sv */
package flbc_pkg;

    localparam int TIME_W      = 32;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_LEAN_PRESSURE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEAN_LAMBDA   = 8'd1;

    localparam logic [CFG_DATA_W-1:0] LEAN_PRESSURE_RESET = 16'h0000;
    localparam logic [CFG_DATA_W-1:0] LEAN_LAMBDA_RESET   = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_STEADY = 2'd1,
        MODE_SLOW   = 2'd2,
        MODE_FAST   = 2'd3
    } mode_t;

    typedef struct packed {
        logic              valid;
        mode_t             mode;
        logic [TIME_W-1:0] elapsed;
    } stage_t;

endpackage

/* rtl/flbc_blink_pipe.sv */
module flbc_blink_pipe #(
    parameter int unsigned SLOW_HALF_PERIOD_US = 500000,
    parameter int unsigned FAST_HALF_PERIOD_US = 200000
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  flbc_pkg::stage_t     stage_in,
    output logic                 out_valid,
    output logic                 out_lamp_on,
    output flbc_pkg::mode_t      out_lamp_mode
);

    // reciprocal constants: q_est = (e * M) >> K is q or q - 1
    localparam int unsigned SLOW_K   = 31 + $clog2(SLOW_HALF_PERIOD_US);
    localparam int unsigned FAST_K   = 31 + $clog2(FAST_HALF_PERIOD_US);
    localparam logic [63:0] SLOW_M64 = (64'd1 << SLOW_K) / 64'(SLOW_HALF_PERIOD_US);
    localparam logic [63:0] FAST_M64 = (64'd1 << FAST_K) / 64'(FAST_HALF_PERIOD_US);
    localparam logic [31:0] SLOW_M   = SLOW_M64[31:0];
    localparam logic [31:0] FAST_M   = FAST_M64[31:0];
    localparam logic [31:0] SLOW_H   = 32'(SLOW_HALF_PERIOD_US);
    localparam logic [31:0] FAST_H   = 32'(FAST_HALF_PERIOD_US);

    logic                          s2_valid_reg;
    flbc_pkg::mode_t               s2_mode_reg;
    logic [flbc_pkg::TIME_W-1:0]   s2_elapsed_reg;
    logic [63:0]                   s2_prod_reg;
    logic [63:0]                   s2_prod_next;

    logic                          s3_valid_reg;
    flbc_pkg::mode_t               s3_mode_reg;
    logic [flbc_pkg::TIME_W-1:0]   s3_elapsed_reg;
    logic                          s3_q0_reg;
    logic                          s3_q0_next;
    logic [31:0]                   s3_qh_reg;
    logic [31:0]                   s3_qh_next;

    logic                          out_valid_reg;
    logic                          out_lamp_reg;
    logic                          out_lamp_next;
    flbc_pkg::mode_t               out_mode_reg;

    logic [31:0] m_sel;
    logic [63:0] q_est;
    logic [31:0] h_sel2;
    logic [63:0] qh_full;
    logic [31:0] h_sel3;
    logic [31:0] rem;
    logic        blink;

    // stage 2: multiply by reciprocal
    always_comb
    begin
        m_sel        = (stage_in.mode == flbc_pkg::MODE_FAST) ? FAST_M : SLOW_M;
        s2_prod_next = 64'(stage_in.elapsed) * 64'(m_sel);
    end

    // stage 3: estimated quotient and its product with the half-period
    always_comb
    begin
        if (s2_mode_reg == flbc_pkg::MODE_FAST)
        begin
            q_est  = s2_prod_reg >> FAST_K;
            h_sel2 = FAST_H;
        end
        else
        begin
            q_est  = s2_prod_reg >> SLOW_K;
            h_sel2 = SLOW_H;
        end
        qh_full    = 64'(q_est[31:0]) * 64'(h_sel2);
        s3_q0_next = q_est[0];
        s3_qh_next = qh_full[31:0];
    end

    // output: one correction step, then lamp level by mode
    always_comb
    begin
        h_sel3 = (s3_mode_reg == flbc_pkg::MODE_FAST) ? FAST_H : SLOW_H;
        rem    = s3_elapsed_reg - s3_qh_reg;
        blink  = s3_q0_reg ^ (rem >= h_sel3);
        case (s3_mode_reg)
            flbc_pkg::MODE_NONE:   out_lamp_next = 1'b0;
            flbc_pkg::MODE_STEADY: out_lamp_next = 1'b1;
            flbc_pkg::MODE_SLOW:   out_lamp_next = blink;
            flbc_pkg::MODE_FAST:   out_lamp_next = blink;
            default:               out_lamp_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg  <= stage_in.valid;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_mode_reg    <= stage_in.mode;
            s2_elapsed_reg <= stage_in.elapsed;
            s2_prod_reg    <= s2_prod_next;
            s3_mode_reg    <= s2_mode_reg;
            s3_elapsed_reg <= s2_elapsed_reg;
            s3_q0_reg      <= s3_q0_next;
            s3_qh_reg      <= s3_qh_next;
            out_mode_reg   <= s3_mode_reg;
            out_lamp_reg   <= out_lamp_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_lamp_on   = out_lamp_reg;
    assign out_lamp_mode = out_mode_reg;

endmodule

/* rtl/fault_lamp_blink_controller.sv */
// Check-engine lamp controller. Each input transfer is one task tick; each tick yields
// exactly one output transfer with the lamp level and the held mode (0 none, 1 steady,
// 2 slow blink, 3 fast blink), in order. A new tick is taken every cycle while the output
// is not stalled. The rate is set by the held-mode loop, a wrap-safe elapsed-time
// subtract, hold compare and rank compare; the blink phase (elapsed time over the
// half-period) follows in a three-stage reciprocal-multiply pipeline. A stalled output
// holds the whole pipeline. Lean-limit registers are written on the cfg channel, which
// is always ready; writes to unknown indexes are dropped.
module fault_lamp_blink_controller #(
    parameter int unsigned SLOW_HALF_PERIOD_US = 500000,
    parameter int unsigned FAST_HALF_PERIOD_US = 200000,
    parameter int unsigned HOLD_TIME_US        = 3000000
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // tdata: now_us[31:0], any_sensor_fault[32], decoder_valid[33], engine_rpm[49:34],
    //        map_pressure[65:50], ego_lambda[81:66], zero[87:82]
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [flbc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tdata: lamp_on[0], lamp_mode[2:1], zero[7:3]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [flbc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [flbc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [flbc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam logic [flbc_pkg::TIME_W-1:0] HOLD_T = flbc_pkg::TIME_W'(HOLD_TIME_US);

    logic [flbc_pkg::CFG_DATA_W-1:0] lean_pressure_reg;
    logic [flbc_pkg::CFG_DATA_W-1:0] lean_lambda_reg;

    flbc_pkg::mode_t                 held_mode_reg;
    flbc_pkg::mode_t                 held_mode_next;
    logic [flbc_pkg::TIME_W-1:0]     start_time_reg;
    logic [flbc_pkg::TIME_W-1:0]     start_time_next;

    logic                            s1_valid_reg;
    flbc_pkg::mode_t                 s1_mode_reg;
    logic [flbc_pkg::TIME_W-1:0]     s1_elapsed_reg;
    logic [flbc_pkg::TIME_W-1:0]     s1_elapsed_next;

    logic [flbc_pkg::TIME_W-1:0]     now_us;
    logic                            any_sensor_fault;
    logic                            decoder_valid;
    logic [15:0]                     engine_rpm;
    logic [15:0]                     map_pressure;
    logic [15:0]                     ego_lambda;

    flbc_pkg::mode_t                 class_mode;
    flbc_pkg::mode_t                 held_eff;
    logic [flbc_pkg::TIME_W-1:0]     diff;
    logic                            advance;
    logic                            accept;
    flbc_pkg::stage_t                stage1;
    logic                            pipe_valid;
    logic                            pipe_lamp_on;
    flbc_pkg::mode_t                 pipe_lamp_mode;

    assign now_us           = s_axis_tdata[31:0];
    assign any_sensor_fault = s_axis_tdata[32];
    assign decoder_valid    = s_axis_tdata[33];
    assign engine_rpm       = s_axis_tdata[49:34];
    assign map_pressure     = s_axis_tdata[65:50];
    assign ego_lambda       = s_axis_tdata[81:66];

    assign advance       = !pipe_valid || m_axis_tready;
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        if (map_pressure > lean_pressure_reg && ego_lambda > lean_lambda_reg)
            class_mode = flbc_pkg::MODE_FAST;
        else if (!decoder_valid && engine_rpm != 16'd0)
            class_mode = flbc_pkg::MODE_SLOW;
        else if (any_sensor_fault)
            class_mode = flbc_pkg::MODE_STEADY;
        else
            class_mode = flbc_pkg::MODE_NONE;

        diff     = now_us - start_time_reg;
        held_eff = (diff > HOLD_T) ? flbc_pkg::MODE_NONE : held_mode_reg;

        if (class_mode > held_eff)
        begin
            held_mode_next  = class_mode;
            start_time_next = now_us;
            s1_elapsed_next = '0;
        end
        else
        begin
            held_mode_next  = held_eff;
            start_time_next = start_time_reg;
            s1_elapsed_next = diff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lean_pressure_reg <= flbc_pkg::LEAN_PRESSURE_RESET;
            lean_lambda_reg   <= flbc_pkg::LEAN_LAMBDA_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                flbc_pkg::CFG_LEAN_PRESSURE: lean_pressure_reg <= cfg_data;
                flbc_pkg::CFG_LEAN_LAMBDA:   lean_lambda_reg   <= cfg_data;
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_mode_reg  <= flbc_pkg::MODE_NONE;
            start_time_reg <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                held_mode_reg  <= held_mode_next;
                start_time_reg <= start_time_next;
            end
            if (advance)
                s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_mode_reg    <= held_mode_next;
            s1_elapsed_reg <= s1_elapsed_next;
        end
    end

    assign stage1.valid   = s1_valid_reg;
    assign stage1.mode    = s1_mode_reg;
    assign stage1.elapsed = s1_elapsed_reg;

    flbc_blink_pipe #(
        .SLOW_HALF_PERIOD_US (SLOW_HALF_PERIOD_US),
        .FAST_HALF_PERIOD_US (FAST_HALF_PERIOD_US)
    ) u_blink_pipe (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .stage_in      (stage1),
        .out_valid     (pipe_valid),
        .out_lamp_on   (pipe_lamp_on),
        .out_lamp_mode (pipe_lamp_mode)
    );

    assign m_axis_tvalid = pipe_valid;
    assign m_axis_tdata  = {5'd0, pipe_lamp_mode, pipe_lamp_on};

endmodule

/* rtl/flbc_checker.sv */
module flbc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [flbc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    // no fault held: lamp dark
    a_none_dark: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:1] == flbc_pkg::MODE_NONE |-> !m_axis_tdata[0])
        else $error("lamp lit with no held fault");

    // steady mode: lamp always lit
    a_steady_lit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:1] == flbc_pkg::MODE_STEADY |-> m_axis_tdata[0])
        else $error("lamp dark in steady mode");

    // input side never blocks while the output side is empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // stalled output transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output changed");

endmodule

bind fault_lamp_blink_controller flbc_checker u_flbc_checker (.*);

/* sim/fault_lamp_blink_controller_tb.sv */
module fault_lamp_blink_controller_tb;

    localparam int unsigned SLOW_HALF_US = 500000;
    localparam int unsigned FAST_HALF_US = 200000;
    localparam int unsigned HOLD_US      = 3000000;
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int          PHASE_TICKS  = 100;
    localparam int          NUM_PHASES   = 5;
    localparam int          LONG_STALL   = 200;

    typedef struct {
        logic [31:0] now_us;
        logic        fault;
        logic        dec_valid;
        logic [15:0] rpm;
        logic [15:0] map;
        logic [15:0] lambda;
    } tick_t;

    typedef struct {
        logic            lamp;
        flbc_pkg::mode_t mode;
    } lamp_out_t;

    typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t       kind;
        logic [7:0]      idx;
        logic [15:0]     data;
        tick_t           tick;
        bit              typed;
        lamp_out_t       want;
    } dir_row_t;

    logic                              clk;
    logic                              rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [flbc_pkg::IN_TDATA_W-1:0]   s_axis_tdata;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [flbc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [flbc_pkg::CFG_INDEX_W-1:0]  cfg_index;
    logic [flbc_pkg::CFG_DATA_W-1:0]   cfg_data;

    // predictor state
    flbc_pkg::mode_t held_mode;
    logic [31:0]     start_time;
    logic [15:0]     lean_press_lim;
    logic [15:0]     lean_lambda_lim;

    lamp_out_t   lamp_q[$];
    int          fails;
    int          ticks_sent;
    int unsigned cycles;
    bit          quiet;
    bit          long_done;
    int          rx_wait;
    logic [31:0] cursor;

    fault_lamp_blink_controller #(
        .SLOW_HALF_PERIOD_US (SLOW_HALF_US),
        .FAST_HALF_PERIOD_US (FAST_HALF_US),
        .HOLD_TIME_US        (HOLD_US)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic lamp_out_t advance_lamp(input tick_t t);
        flbc_pkg::mode_t rank;
        logic [31:0]     elapsed;
        lamp_out_t       r;
        if (t.map > lean_press_lim && t.lambda > lean_lambda_lim)
            rank = flbc_pkg::MODE_FAST;
        else if (!t.dec_valid && t.rpm != 16'd0)
            rank = flbc_pkg::MODE_SLOW;
        else if (t.fault)
            rank = flbc_pkg::MODE_STEADY;
        else
            rank = flbc_pkg::MODE_NONE;
        elapsed = t.now_us - start_time;
        if (elapsed > HOLD_US)
            held_mode = flbc_pkg::MODE_NONE;
        if (rank > held_mode)
        begin
            held_mode  = rank;
            start_time = t.now_us;
        end
        elapsed = t.now_us - start_time;
        case (held_mode)
            flbc_pkg::MODE_STEADY: r.lamp = 1'b1;
            flbc_pkg::MODE_SLOW:   r.lamp = 1'(elapsed / SLOW_HALF_US % 2);
            flbc_pkg::MODE_FAST:   r.lamp = 1'(elapsed / FAST_HALF_US % 2);
            default:               r.lamp = 1'b0;
        endcase
        r.mode = held_mode;
        return r;
    endfunction

    function automatic dir_row_t tick_row(input logic [31:0] now, input logic fault,
                                          input logic dv, input logic [15:0] rpm,
                                          input logic [15:0] map, input logic [15:0] lambda,
                                          input bit typed, input logic lamp,
                                          input flbc_pkg::mode_t mode);
        dir_row_t r;
        r.kind             = ROW_TICK;
        r.idx              = '0;
        r.data             = '0;
        r.tick.now_us      = now;
        r.tick.fault       = fault;
        r.tick.dec_valid   = dv;
        r.tick.rpm         = rpm;
        r.tick.map         = map;
        r.tick.lambda      = lambda;
        r.typed            = typed;
        r.want.lamp        = lamp;
        r.want.mode        = mode;
        return r;
    endfunction

    function automatic dir_row_t reg_row(input logic [7:0] idx, input logic [15:0] data);
        dir_row_t r;
        r      = tick_row(32'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0,
                          flbc_pkg::MODE_NONE);
        r.kind = ROW_REG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    function automatic logic [15:0] pick_above(input logic [15:0] lim);
        int span;
        if (lim == 16'hFFFF)
            return 16'($urandom);
        span = 65535 - int'(lim);
        if ($urandom_range(0, 1))
            return 16'(int'(lim) + 1 + int'($urandom_range(0, span - 1)));
        return 16'(int'(lim) + 1 + int'($urandom_range(0, (span > 4) ? 3 : span - 1)));
    endfunction

    function automatic logic [15:0] pick_not_above(input logic [15:0] lim);
        if ($urandom_range(0, 1))
            return 16'($urandom_range(0, int'(lim)));
        return 16'(int'(lim) - int'($urandom_range(0, (lim > 3) ? 3 : int'(lim))));
    endfunction

    function automatic tick_t gen_tick();
        tick_t t;
        int    sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            cursor = cursor + 32'(10000 + $urandom_range(0, 2000));
        else if (sel < 78)
            cursor = cursor + 32'($urandom_range(0, 700000));
        else if (sel < 88)
            cursor = cursor + 32'($urandom_range(0, 4000000));
        else if (sel < 94)
            cursor = start_time + HOLD_US - 1 + 32'($urandom_range(0, 2));
        else if (sel < 97)
            cursor = 32'hFFFFFFFF - 32'($urandom_range(0, 30000));
        else
            cursor = $urandom;
        t.now_us    = cursor;
        t.fault     = ($urandom_range(0, 2) == 0);
        t.dec_valid = ($urandom_range(0, 3) != 0);
        t.rpm       = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
        sel = $urandom_range(0, 9);
        if (sel < 3)
        begin
            t.map    = pick_above(lean_press_lim);
            t.lambda = pick_above(lean_lambda_lim);
        end
        else if (sel == 3)
        begin
            t.map    = pick_above(lean_press_lim);
            t.lambda = pick_not_above(lean_lambda_lim);
        end
        else if (sel == 4)
        begin
            t.map    = pick_not_above(lean_press_lim);
            t.lambda = pick_above(lean_lambda_lim);
        end
        else
        begin
            t.map    = 16'($urandom);
            t.lambda = 16'($urandom);
        end
        return t;
    endfunction

    task automatic send_tick(input tick_t t, input bit typed, input lamp_out_t want);
        lamp_out_t pred;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, t.lambda, t.map, t.rpm, t.dec_valid, t.fault, t.now_us};
        do @(posedge clk); while (!s_axis_tready);
        pred = advance_lamp(t);
        lamp_q.push_back(typed ? want : pred);
        ticks_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (lamp_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == flbc_pkg::CFG_LEAN_PRESSURE)
            lean_press_lim = val;
        else if (idx == flbc_pkg::CFG_LEAN_LAMBDA)
            lean_lambda_lim = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // receiver: random backpressure plus one long hold-off
    always @(posedge clk)
    begin
        if (rx_wait > 0)
        begin
            rx_wait       <= rx_wait - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!long_done && ticks_sent >= 150)
        begin
            long_done     <= 1'b1;
            rx_wait       <= LONG_STALL;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            rx_wait       <= $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        lamp_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (lamp_q.size() == 0)
            begin
                $display("%0t: unexpected transfer, actual tdata %h", $time, m_axis_tdata);
                fails++;
            end
            else
            begin
                want = lamp_q.pop_front();
                if (m_axis_tdata[0] !== want.lamp)
                begin
                    $display("%0t: lamp_on expected %0b actual %0b",
                             $time, want.lamp, m_axis_tdata[0]);
                    fails++;
                end
                if (m_axis_tdata[2:1] !== want.mode)
                begin
                    $display("%0t: lamp_mode expected %0d actual %0d",
                             $time, want.mode, m_axis_tdata[2:1]);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("fault_lamp_blink_controller_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        dir_row_t    script[$];
        tick_t       t;
        lamp_out_t   none_out;
        logic [15:0] press_set[NUM_PHASES];
        logic [15:0] lambda_set[NUM_PHASES];

        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        m_axis_tready   = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        fails           = 0;
        ticks_sent      = 0;
        cycles          = 0;
        quiet           = 1'b0;
        long_done       = 1'b0;
        rx_wait         = 0;
        cursor          = 32'd0;
        held_mode       = flbc_pkg::MODE_NONE;
        start_time      = 32'd0;
        lean_press_lim  = flbc_pkg::LEAN_PRESSURE_RESET;
        lean_lambda_lim = flbc_pkg::LEAN_LAMBDA_RESET;
        none_out.lamp   = 1'b0;
        none_out.mode   = flbc_pkg::MODE_NONE;

        // reset limits: lean never seen; hold boundary, wrap, time going back
        script.push_back(tick_row(32'd0, 0, 1, 16'd0, 16'd0, 16'd0, 1, 0,
                                  flbc_pkg::MODE_NONE));
        script.push_back(tick_row(32'd100, 1, 1, 16'd0, 16'd0, 16'd0, 1, 1,
                                  flbc_pkg::MODE_STEADY));
        script.push_back(tick_row(32'd200, 0, 0, 16'd1, 16'd0, 16'd0, 1, 0,
                                  flbc_pkg::MODE_SLOW));
        script.push_back(tick_row(32'd500200, 0, 1, 16'd0, 16'd0, 16'd0, 1, 1,
                                  flbc_pkg::MODE_SLOW));
        script.push_back(tick_row(32'd3000200, 0, 1, 16'd0, 16'd0, 16'd0, 1, 0,
                                  flbc_pkg::MODE_SLOW));
        script.push_back(tick_row(32'd3000201, 0, 1, 16'd0, 16'd0, 16'd0, 1, 0,
                                  flbc_pkg::MODE_NONE));
        script.push_back(tick_row(32'd3000300, 1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  1, 1, flbc_pkg::MODE_STEADY));
        script.push_back(tick_row(32'hFFFFFFFF, 1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  1, 1, flbc_pkg::MODE_STEADY));
        script.push_back(tick_row(32'd10, 0, 0, 16'hFFFF, 16'd0, 16'd0, 1, 0,
                                  flbc_pkg::MODE_SLOW));
        script.push_back(tick_row(32'd5, 0, 1, 16'd0, 16'd0, 16'd0, 1, 0,
                                  flbc_pkg::MODE_NONE));
        script.push_back(reg_row(flbc_pkg::CFG_LEAN_LAMBDA, 16'h1000));
        script.push_back(tick_row(32'd1000, 0, 1, 16'd0, 16'd1, 16'h1001, 1, 0,
                                  flbc_pkg::MODE_FAST));
        script.push_back(tick_row(32'd201000, 0, 1, 16'd0, 16'd1, 16'h1001, 1, 1,
                                  flbc_pkg::MODE_FAST));
        script.push_back(tick_row(32'd401000, 0, 0, 16'd5, 16'd1, 16'h1000, 0, 0,
                                  flbc_pkg::MODE_NONE));
        script.push_back(tick_row(32'd601000, 0, 1, 16'd0, 16'd0, 16'hFFFF, 0, 0,
                                  flbc_pkg::MODE_NONE));
        script.push_back(reg_row(8'd2, 16'hFFFF));
        script.push_back(reg_row(8'hFF, 16'h0000));
        script.push_back(tick_row(32'd801000, 0, 1, 16'd0, 16'd1, 16'h1001, 0, 0,
                                  flbc_pkg::MODE_NONE));
        script.push_back(reg_row(flbc_pkg::CFG_LEAN_PRESSURE, 16'hFFFF));
        script.push_back(reg_row(flbc_pkg::CFG_LEAN_LAMBDA, 16'h0000));
        script.push_back(tick_row(32'd1001000, 0, 1, 16'd0, 16'hFFFF, 16'hFFFF,
                                  1, 1, flbc_pkg::MODE_FAST));
        script.push_back(reg_row(flbc_pkg::CFG_LEAN_PRESSURE, 16'hFFFE));
        script.push_back(tick_row(32'd4001001, 0, 1, 16'd0, 16'hFFFF, 16'd1, 1, 0,
                                  flbc_pkg::MODE_FAST));
        script.push_back(tick_row(32'd4001002, 1, 0, 16'd0, 16'd0, 16'd0, 0, 0,
                                  flbc_pkg::MODE_NONE));

        press_set[0]  = 16'h0000;
        lambda_set[0] = 16'hFFFF;
        press_set[1]  = 16'h0000;
        lambda_set[1] = 16'h0000;
        press_set[2]  = 16'($urandom);
        lambda_set[2] = 16'($urandom);
        press_set[3]  = 16'hFFFF;
        lambda_set[3] = 16'h0000;
        press_set[4]  = 16'($urandom_range(16'h4000, 16'hC000));
        lambda_set[4] = 16'($urandom_range(16'h4000, 16'hC000));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_REG)
            begin
                wait_drained();
                write_reg(script[i].idx, script[i].data);
            end
            else
                send_tick(script[i].tick, script[i].typed, script[i].want);
        end

        cursor = 32'd4001002;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            write_reg(flbc_pkg::CFG_LEAN_PRESSURE, press_set[p]);
            write_reg(flbc_pkg::CFG_LEAN_LAMBDA, lambda_set[p]);
            write_reg(8'($urandom_range(2, 255)), 16'($urandom));
            quiet = (p == NUM_PHASES - 1);
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                t = gen_tick();
                send_tick(t, 1'b0, none_out);
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("fault_lamp_blink_controller_tb: done, clean");
        else
            $display("fault_lamp_blink_controller_tb: done, errors");
        $finish;
    end

endmodule
